### hw/rtl/outline_path_flattener_defines.svh
// Assertion macros for the outline path flattener.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef OUTLINE_PATH_FLATTENER_DEFINES_SVH
`define OUTLINE_PATH_FLATTENER_DEFINES_SVH

// same-cycle implication
`define OPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/opf_pkg.sv
// Shared types, codes and constants of the outline path flattener.
// No dependencies.
package opf_pkg;

  localparam int unsigned MAX_STEPS_DEF = 64;
  localparam int unsigned COORD_W       = 24;
  localparam int unsigned OUTY_W        = 25;
  localparam int unsigned ASC_W         = 23;
  localparam int unsigned IN_TDATA_W    = 96;
  localparam int unsigned OUT_TDATA_W   = 56;

  localparam logic [1:0] MODE_MOVE  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_CONIC = 2'd2;
  localparam logic [1:0] MODE_CUBIC = 2'd3;

  localparam int unsigned SUM_W      = 52;
  localparam int unsigned SQRT_TOP   = 50;
  localparam int unsigned SQRT_STEPS = 26;
  localparam int unsigned PDIV_STEPS = 24;
  localparam int unsigned SEG_DIV    = 100;
  localparam int unsigned CNT_W      = 5;

  // floor(r/100) as (r * RCP_MUL) >> RCP_SH, exact for r below 100 * 1024
  localparam int unsigned RLO_W   = 17;
  localparam int unsigned RCP_W   = 18;
  localparam int unsigned RCP_SH  = 24;
  localparam int unsigned RCP_MUL = 167773;

  localparam logic [3:0] M_NONE = 4'd0;
  localparam logic [3:0] M_DX1  = 4'd1;
  localparam logic [3:0] M_DY1  = 4'd2;
  localparam logic [3:0] M_DX2  = 4'd3;
  localparam logic [3:0] M_DY2  = 4'd4;
  localparam logic [3:0] M_DEN  = 4'd5;
  localparam logic [3:0] M_CA   = 4'd6;
  localparam logic [3:0] M_CB   = 4'd7;
  localparam logic [3:0] M_CC   = 4'd8;
  localparam logic [3:0] M_AX   = 4'd9;
  localparam logic [3:0] M_BX   = 4'd10;
  localparam logic [3:0] M_CX   = 4'd11;
  localparam logic [3:0] M_AY   = 4'd12;
  localparam logic [3:0] M_BY   = 4'd13;
  localparam logic [3:0] M_CY   = 4'd14;

  typedef struct packed {
    logic       load;
    logic [3:0] mul_op;
    logic       clr_sum;
    logic       clr_num;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       n_load;
    logic       k_init;
    logic       k_inc;
    logic       pdiv_init;
    logic       pdiv_step;
    logic       emit_pt;
    logic       emit_end;
  } opf_cmd_t;

  typedef struct packed {
    logic in_conic;
    logic n_lt2;
    logic k_last;
    logic out_free;
  } opf_stat_t;

endpackage

### hw/rtl/outline_path_flattener.sv
// Top level of the outline path flattener: sequencer plus datapath.
// Depends on opf_pkg, opf_ctrl, opf_dpath and outline_path_flattener_defines.svh.
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   tuser mode, tdata to_x,to_y,ctrl_x,ctrl_y
//  out_     out  out_tvalid/out_tready tuser point_kind, tlast last_point, tdata out_x,out_y
//  cfg_     in   cfg_valid/cfg_ready   cfg_data ascent_scaled
//
// Move, line, cubic: straight to the end point. Conic: squares, square root
// and step count first, then per interior point the coefficients, products
// and the 24-step restoring divider, up to MAX_STEPS-1 interior points, then
// the end point. Output stalls delay the sequencer at each emitted point.
// One command at a time; the output register lets the next command in while
// the last point waits. Synchronous active-low reset clears pen point and ascent.
`include "outline_path_flattener_defines.svh"
module outline_path_flattener import opf_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // to_x, to_y, ctrl_x, ctrl_y
  input  logic [1:0]             in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_x, out_y, zero pad
  output logic                   out_tuser,  // point_kind
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ASC_W-1:0]       cfg_data
);

  opf_cmd_t  cmd;
  opf_stat_t stat;

  assign cfg_ready = 1'b1;

  opf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  opf_dpath #(.MAX_STEPS(MAX_STEPS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

  `OPF_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `OPF_ASSERT_IMP(a_interior_busy, out_tvalid && !out_tlast, !in_tready, "idle with interior point")
  `OPF_ASSERT_IMP(a_interior_line, out_tvalid && !out_tlast, out_tuser, "interior point not line-to")

endmodule

### hw/rtl/opf_ctrl.sv
// Sequencer of the outline path flattener.
// Depends on opf_pkg; drives opf_dpath through opf_cmd_t.
module opf_ctrl import opf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  opf_stat_t stat,
  output opf_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ    = 5'd1;
  localparam logic [4:0] S_SQW   = 5'd2;
  localparam logic [4:0] S_SQI   = 5'd3;
  localparam logic [4:0] S_SQRT  = 5'd4;
  localparam logic [4:0] S_NLD   = 5'd5;
  localparam logic [4:0] S_NCHK  = 5'd6;
  localparam logic [4:0] S_COEF  = 5'd7;
  localparam logic [4:0] S_COEFW = 5'd8;
  localparam logic [4:0] S_PROD  = 5'd9;
  localparam logic [4:0] S_PRODW = 5'd10;
  localparam logic [4:0] S_PINIT = 5'd11;
  localparam logic [4:0] S_PDIV  = 5'd12;
  localparam logic [4:0] S_PEMIT = 5'd13;
  localparam logic [4:0] S_END   = 5'd14;

  logic [4:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_op = M_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.clr_sum = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = stat.in_conic ? S_SQ : S_END;
        end
      end
      S_SQ: begin
        case (cnt_r[1:0])
          2'd0:    cmd.mul_op = M_DX1;
          2'd1:    cmd.mul_op = M_DY1;
          2'd2:    cmd.mul_op = M_DX2;
          default: cmd.mul_op = M_DY2;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) state_nxt = S_SQW;
      end
      S_SQW: state_nxt = S_SQI;
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_NLD;
      end
      S_NLD: begin
        cmd.n_load = 1'b1;
        state_nxt  = S_NCHK;
      end
      S_NCHK: begin
        if (stat.n_lt2) begin
          state_nxt = S_END;
        end else begin
          cmd.mul_op = M_DEN;
          cmd.k_init = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_COEF;
        end
      end
      S_COEF: begin
        case (cnt_r[1:0])
          2'd0:    cmd.mul_op = M_CA;
          2'd1:    cmd.mul_op = M_CB;
          default: cmd.mul_op = M_CC;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(2)) state_nxt = S_COEFW;
      end
      S_COEFW: begin
        cmd.clr_num = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_PROD;
      end
      S_PROD: begin
        case (cnt_r[2:0])
          3'd0:    cmd.mul_op = M_AX;
          3'd1:    cmd.mul_op = M_BX;
          3'd2:    cmd.mul_op = M_CX;
          3'd3:    cmd.mul_op = M_AY;
          3'd4:    cmd.mul_op = M_BY;
          default: cmd.mul_op = M_CY;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(5)) state_nxt = S_PRODW;
      end
      S_PRODW: state_nxt = S_PINIT;
      S_PINIT: begin
        cmd.pdiv_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_PDIV;
      end
      S_PDIV: begin
        cmd.pdiv_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PDIV_STEPS - 1)) state_nxt = S_PEMIT;
      end
      S_PEMIT: begin
        if (stat.out_free) begin
          cmd.emit_pt = 1'b1;
          cnt_nxt     = '0;
          if (stat.k_last) begin
            state_nxt = S_END;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_COEF;
          end
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/opf_dpath.sv
// Datapath of the outline path flattener: pen point, shared multiplier,
// square root, divide by 100, per-point dividers and output register. Uses opf_pkg.
module opf_dpath import opf_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  opf_cmd_t               cmd,
  output opf_stat_t              stat,
  input  logic [1:0]             in_mode,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_we,
  input  logic [ASC_W-1:0]       cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_kind,
  output logic                   out_last
);

  localparam int unsigned NW      = $clog2(MAX_STEPS + 1);
  localparam int unsigned CW      = 2 * NW;
  localparam int unsigned MA      = (CW + 1 > 26) ? CW + 1 : 26;
  localparam int unsigned PW      = MA + 25;
  localparam int unsigned NUMW    = CW + 26;
  localparam int unsigned DSW     = CW + PDIV_STEPS - 1;
  localparam int unsigned SEG_LIM = SEG_DIV * MAX_STEPS;

  logic [1:0]                 mode_r;
  logic signed [COORD_W-1:0]  tox_r, toy_r, cx_r, cy_r, lastx_r, lasty_r;
  logic [ASC_W-1:0]           asc_r;
  logic signed [24:0]         dx1, dy1, dx2, dy2;
  logic signed [MA-1:0]       opa;
  logic signed [24:0]         opb;
  logic signed [PW-1:0]       prod_nxt, prod_r;
  logic [3:0]                 op_r;
  logic [SUM_W-1:0]           sum_r, sv_r, sres_r, sbit_r, strial;
  logic [RLO_W-1:0]           root_lo;
  logic [RLO_W+RCP_W-1:0]     rcp_prod;
  logic [NW-1:0]              n_r, k_r, nmk;
  logic [CW-1:0]              den_r, a_r, b_r, c_r;
  logic signed [NUMW-1:0]     numx_r, numy_r;
  logic [NUMW-1:0]            remx_r, remy_r, dsh_ext;
  logic [DSW-1:0]             dsh_r;
  logic [PDIV_STEPS-1:0]      qx_r, qy_r;
  logic                       negx_r, negy_r, gex, gey;
  logic signed [COORD_W-1:0]  px, py, selx, sely;
  logic signed [OUTY_W-1:0]   fy;
  logic                       out_valid_r;
  logic [OUT_TDATA_W-1:0]     out_data_r;
  logic                       out_kind_r, out_last_r;

  assign dx1 = 25'(tox_r) - 25'(lastx_r);
  assign dy1 = 25'(toy_r) - 25'(lasty_r);
  assign dx2 = 25'(tox_r) - 25'(cx_r);
  assign dy2 = 25'(toy_r) - 25'(cy_r);
  assign nmk = n_r - k_r;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mul_op)
      M_DX1: begin opa = MA'(dx1); opb = dx1; end
      M_DY1: begin opa = MA'(dy1); opb = dy1; end
      M_DX2: begin opa = MA'(dx2); opb = dx2; end
      M_DY2: begin opa = MA'(dy2); opb = dy2; end
      M_DEN: begin opa = signed'(MA'(n_r)); opb = signed'(25'(n_r)); end
      M_CA:  begin opa = signed'(MA'(nmk)); opb = signed'(25'(nmk)); end
      M_CB:  begin opa = signed'(MA'(k_r)); opb = signed'(25'(nmk)); end
      M_CC:  begin opa = signed'(MA'(k_r)); opb = signed'(25'(k_r)); end
      M_AX:  begin opa = signed'(MA'(a_r)); opb = 25'(lastx_r); end
      M_BX:  begin opa = signed'(MA'(b_r)); opb = 25'(cx_r); end
      M_CX:  begin opa = signed'(MA'(c_r)); opb = 25'(tox_r); end
      M_AY:  begin opa = signed'(MA'(a_r)); opb = 25'(lasty_r); end
      M_BY:  begin opa = signed'(MA'(b_r)); opb = 25'(cy_r); end
      M_CY:  begin opa = signed'(MA'(c_r)); opb = 25'(toy_r); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_nxt = opa * opb;

  assign strial   = sres_r + sbit_r;
  assign root_lo  = sres_r[RLO_W-1:0];
  assign rcp_prod = root_lo * RCP_W'(RCP_MUL);
  assign dsh_ext  = NUMW'(dsh_r);
  assign gex      = (remx_r >= dsh_ext);
  assign gey      = (remy_r >= dsh_ext);
  assign px       = negx_r ? -signed'(qx_r) : signed'(qx_r);
  assign py       = negy_r ? -signed'(qy_r) : signed'(qy_r);

  assign selx = cmd.emit_end ? tox_r : px;
  assign sely = cmd.emit_end ? toy_r : py;
  assign fy   = signed'({2'b00, asc_r}) - 25'(sely);

  assign stat.in_conic = (in_mode == MODE_CONIC);
  assign stat.n_lt2    = (n_r < NW'(2));
  assign stat.k_last   = (k_r == n_r - 1'b1);
  assign stat.out_free = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lastx_r     <= '0;
      lasty_r     <= '0;
      asc_r       <= '0;
      out_valid_r <= 1'b0;
      op_r        <= M_NONE;
    end else begin
      op_r <= cmd.mul_op;
      if (cfg_we) asc_r <= cfg_data;
      if (cmd.emit_end) begin
        lastx_r <= tox_r;
        lasty_r <= toy_r;
      end
      if (cmd.emit_pt || cmd.emit_end) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      mode_r <= in_mode;
      tox_r  <= in_data[23:0];
      toy_r  <= in_data[47:24];
      cx_r   <= in_data[71:48];
      cy_r   <= in_data[95:72];
    end
    if (cmd.clr_sum) sum_r <= '0;
    else if (op_r == M_DX1 || op_r == M_DY1 || op_r == M_DX2 || op_r == M_DY2)
      sum_r <= sum_r + SUM_W'(prod_r);
    if (op_r == M_DEN) den_r <= prod_r[CW-1:0];
    if (op_r == M_CA)  a_r   <= prod_r[CW-1:0];
    if (op_r == M_CB)  b_r   <= {prod_r[CW-2:0], 1'b0};
    if (op_r == M_CC)  c_r   <= prod_r[CW-1:0];
    if (cmd.clr_num) begin
      numx_r <= '0;
      numy_r <= '0;
    end else begin
      if (op_r == M_AX || op_r == M_BX || op_r == M_CX) numx_r <= numx_r + NUMW'(prod_r);
      if (op_r == M_AY || op_r == M_BY || op_r == M_CY) numy_r <= numy_r + NUMW'(prod_r);
    end
    if (cmd.sqrt_init) begin
      sv_r   <= sum_r;
      sres_r <= '0;
      sbit_r <= SUM_W'(1) << SQRT_TOP;
    end else if (cmd.sqrt_step) begin
      if (sv_r >= strial) begin
        sv_r   <= sv_r - strial;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    // root / 100, saturated at MAX_STEPS
    if (cmd.n_load)
      n_r <= (sres_r >= SUM_W'(SEG_LIM)) ? NW'(MAX_STEPS) : rcp_prod[RCP_SH +: NW];
    if (cmd.k_init) k_r <= NW'(1);
    else if (cmd.k_inc) k_r <= k_r + 1'b1;
    if (cmd.pdiv_init) begin
      negx_r <= numx_r[NUMW-1];
      negy_r <= numy_r[NUMW-1];
      remx_r <= numx_r[NUMW-1] ? unsigned'(-numx_r) : unsigned'(numx_r);
      remy_r <= numy_r[NUMW-1] ? unsigned'(-numy_r) : unsigned'(numy_r);
      dsh_r  <= DSW'(den_r) << (PDIV_STEPS - 1);
      qx_r   <= '0;
      qy_r   <= '0;
    end else if (cmd.pdiv_step) begin
      if (gex) remx_r <= remx_r - dsh_ext;
      if (gey) remy_r <= remy_r - dsh_ext;
      qx_r  <= {qx_r[PDIV_STEPS-2:0], gex};
      qy_r  <= {qy_r[PDIV_STEPS-2:0], gey};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.emit_pt || cmd.emit_end) begin
      out_data_r <= {7'b0, fy, selx};
      out_kind_r <= cmd.emit_end ? (mode_r != MODE_MOVE) : 1'b1;
      out_last_r <= cmd.emit_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule
